// File: hdl/ces_pkg.sv
// Shared types, constants and helpers for the cable equation stencil step.
// No dependencies; used by ces_front, ces_cell and cable_equation_stencil_step.
`default_nettype none

package ces_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_COUPLING    = 3'd0;
  localparam logic [2:0] REG_SELF_WEIGHT = 3'd1;
  localparam logic [2:0] REG_LEAK_FACTOR = 3'd2;
  localparam logic [2:0] REG_SYN_GAIN    = 3'd3;
  localparam logic [2:0] REG_REST        = 3'd4;

  // Register reset values
  localparam logic [29:0]        COUPLING_RESET = 30'd0;
  localparam logic signed [30:0] SELF_RESET     = 31'sd1073741823;
  localparam logic [29:0]        LEAK_RESET     = 30'd0;
  localparam logic [31:0]        GAIN_RESET     = 32'd65536;
  localparam logic signed [31:0] REST_RESET     = -32'sd18790482;

  // Q3.28 limits and the -1.0 flag value
  localparam logic signed [49:0] Q_MAX     = 50'sd2147483647;
  localparam logic signed [49:0] Q_MIN     = -50'sd2147483648;
  localparam logic signed [31:0] MINUS_ONE = -32'sd268435456;

  // Round-half-up offsets for the product shifts
  localparam logic signed [64:0] HALF16_65 = 65'sd32768;
  localparam logic signed [63:0] HALF30_64 = 64'sd536870912;
  localparam logic signed [62:0] HALF30_63 = 63'sd536870912;

  typedef struct packed {
    logic               restart;
    logic signed [31:0] channel_level;
    logic signed [31:0] feedback;
    logic signed [31:0] synaptic_current;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] far_voltage;
    logic               overflow;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DRIVE,
    ST_MUL,
    ST_ACC,
    ST_PUT
  } state_t;

  // Control into the front end
  typedef struct packed {
    logic capture;
    logic drive;
  } front_ctl_t;

  // Control broadcast along the cell row
  typedef struct packed {
    logic load;
    logic mul;
    logic acc;
  } cell_ctl_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] value;
  } sat_t;

  // Clamp a wide sum to Q3.28 and flag the clamp
  function automatic sat_t sat_q28(input logic signed [49:0] v);
    sat_t r;
    if (v > Q_MAX) begin
      r.hit   = 1'b1;
      r.value = Q_MAX[31:0];
    end else if (v < Q_MIN) begin
      r.hit   = 1'b1;
      r.value = Q_MIN[31:0];
    end else begin
      r.hit   = 1'b0;
      r.value = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hdl/ces_front.sv
// Front end: drive of cell 0 and the shared leak term.
// Depends on ces_pkg.
`default_nettype none

module ces_front (
  input  wire logic                clk,
  input  wire ces_pkg::front_ctl_t ctl,
  input  wire ces_pkg::in_word_t   word,
  input  wire logic [31:0]         synaptic_gain,
  input  wire logic [29:0]         leak_factor,
  output logic signed [31:0]       drive_volt,
  output logic signed [33:0]       leak,
  output logic                     drive_sat
);

  logic signed [32:0] diff_in;
  logic signed [32:0] diff;
  logic signed [64:0] syn_prod;
  logic signed [63:0] leak_prod;
  logic signed [64:0] syn_round;
  logic signed [63:0] leak_round;
  logic signed [49:0] drive_sum;
  ces_pkg::sat_t      drive_clamp;

  assign diff_in = {word.channel_level[31], word.channel_level}
                 - {word.feedback[31], word.feedback};

  // stage 1: products straight off the accepted word
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      diff      <= diff_in;
      syn_prod  <= $signed(word.synaptic_current) * $signed({1'b0, synaptic_gain});
      leak_prod <= diff_in * $signed({1'b0, leak_factor});
    end
  end

  assign syn_round  = syn_prod + ces_pkg::HALF16_65;
  assign leak_round = leak_prod + ces_pkg::HALF30_64;
  assign drive_sum  = {{17{diff[32]}}, diff} + {syn_round[64], syn_round[64:16]};
  assign drive_clamp = ces_pkg::sat_q28(drive_sum);
  assign drive_sat   = drive_clamp.hit;

  // stage 2: round, sum, clamp
  always_ff @(posedge clk) begin
    if (ctl.drive) begin
      drive_volt <= drive_clamp.value;
      leak       <= leak_round[63:30];
    end
  end

endmodule

`default_nettype wire

// File: hdl/ces_cell.sv
// One interior grid cell: neighbor and self products, then leak sum and clamp.
// Depends on ces_pkg.
`default_nettype none

module ces_cell (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ces_pkg::cell_ctl_t  ctl,
  input  wire logic signed [31:0]  rest,
  input  wire logic [29:0]         coupling,
  input  wire logic signed [30:0]  self_weight,
  input  wire logic signed [33:0]  leak,
  input  wire logic signed [31:0]  left,
  input  wire logic signed [31:0]  right,
  output logic signed [31:0]       volt,
  output logic                     sat
);

  logic signed [32:0] nb;
  logic signed [63:0] nb_prod;
  logic signed [62:0] self_prod;
  logic signed [33:0] nb_term;
  logic signed [32:0] self_term;
  logic signed [49:0] sum;
  ces_pkg::sat_t      clamp;

  assign nb        = {left[31], left} + {right[31], right};
  assign nb_prod   = nb * $signed({1'b0, coupling}) + ces_pkg::HALF30_64;
  assign self_prod = volt * self_weight + ces_pkg::HALF30_63;

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      nb_term   <= nb_prod[63:30];
      self_term <= self_prod[62:30];
    end
  end

  assign sum = {{16{leak[33]}}, leak} + {{16{nb_term[33]}}, nb_term}
             + {{17{self_term[32]}}, self_term};
  assign clamp = ces_pkg::sat_q28(sum);
  assign sat   = clamp.hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      volt <= ces_pkg::REST_RESET;
    end else if (ctl.load) begin
      volt <= rest;
    end else if (ctl.acc) begin
      volt <= clamp.value;
    end
  end

endmodule

`default_nettype wire

// File: hdl/cable_equation_stencil_step.sv
// Top level of the cable equation stencil step: config registers, sequencer,
// front end and the row of grid cells. Depends on ces_pkg, ces_front, ces_cell.
`default_nettype none

// One explicit time step of a passive 1-D cable per input word. Cells 1 ..
// GRID_POINTS-1 are a row of ces_cell instances, each holding its Q3.28
// voltage and reading its two neighbors' voltages every cycle; cell 0 is
// driven by the front end and the far cell holds the rest potential. A word
// passes through accept (gain and leak products registered), drive
// (cell 0 and leak term), multiply (neighbor and self products in every
// cell), accumulate (sum, clamp, cell update) and output load. in_ready is
// high only while the sequencer is idle, so the block takes a new word only
// once the last result is in the output register; a stalled result holds the sequencer
// in the output-load step. The output register lets the next word be
// accepted while a result still waits. A restart word reloads cells 1 .. GRID_POINTS
// from rest_potential and clears the sticky overflow flag; while that flag
// is set far_voltage reads -1.0. Registers are written at any edge with
// cfg_we high and should change only while the block is idle.

module cable_equation_stencil_step #(
  parameter int GRID_POINTS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire ces_pkg::in_word_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output ces_pkg::out_word_t      out_data,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  // config registers
  logic [29:0]        coupling;
  logic signed [30:0] self_weight;
  logic [29:0]        leak_factor;
  logic [31:0]        synaptic_gain;
  logic signed [31:0] rest_potential;

  always_ff @(posedge clk) begin
    if (rst) begin
      coupling       <= ces_pkg::COUPLING_RESET;
      self_weight    <= ces_pkg::SELF_RESET;
      leak_factor    <= ces_pkg::LEAK_RESET;
      synaptic_gain  <= ces_pkg::GAIN_RESET;
      rest_potential <= ces_pkg::REST_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ces_pkg::REG_COUPLING:    coupling       <= cfg_data[29:0];
        ces_pkg::REG_SELF_WEIGHT: self_weight    <= cfg_data[30:0];
        ces_pkg::REG_LEAK_FACTOR: leak_factor    <= cfg_data[29:0];
        ces_pkg::REG_SYN_GAIN:    synaptic_gain  <= cfg_data;
        ces_pkg::REG_REST:        rest_potential <= cfg_data;
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  // sequencer
  ces_pkg::state_t     state;
  ces_pkg::state_t     state_next;
  ces_pkg::front_ctl_t front_ctl;
  ces_pkg::cell_ctl_t  cell_ctl;
  logic                accept;
  logic                out_load;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ces_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ces_pkg::ST_IDLE:  if (in_valid) state_next = ces_pkg::ST_DRIVE;
      ces_pkg::ST_DRIVE: state_next = ces_pkg::ST_MUL;
      ces_pkg::ST_MUL:   state_next = ces_pkg::ST_ACC;
      ces_pkg::ST_ACC:   state_next = ces_pkg::ST_PUT;
      ces_pkg::ST_PUT:   if (!out_valid || out_ready) state_next = ces_pkg::ST_IDLE;
      default:           state_next = ces_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready          = (state == ces_pkg::ST_IDLE);
    front_ctl.capture = in_valid && (state == ces_pkg::ST_IDLE);
    front_ctl.drive   = (state == ces_pkg::ST_DRIVE);
    cell_ctl.load     = in_valid && (state == ces_pkg::ST_IDLE) && in_data.restart;
    cell_ctl.mul      = (state == ces_pkg::ST_MUL);
    cell_ctl.acc      = (state == ces_pkg::ST_ACC);
    out_load          = (state == ces_pkg::ST_PUT) && (!out_valid || out_ready);
  end

  // datapath: volt[0] is the driven cell, volt[GRID_POINTS] the far cell
  logic signed [31:0] volt [GRID_POINTS:0];
  logic [GRID_POINTS-1:1] cell_sat;
  logic signed [33:0] leak;
  logic               drive_sat;
  logic signed [31:0] far_cell;
  logic               overflow_seen;

  ces_front u_front (
    .clk           (clk),
    .ctl           (front_ctl),
    .word          (in_data),
    .synaptic_gain (synaptic_gain),
    .leak_factor   (leak_factor),
    .drive_volt    (volt[0]),
    .leak          (leak),
    .drive_sat     (drive_sat)
  );

  for (genvar i = 1; i < GRID_POINTS; i++) begin : g_cell
    ces_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (cell_ctl),
      .rest        (rest_potential),
      .coupling    (coupling),
      .self_weight (self_weight),
      .leak        (leak),
      .left        (volt[i-1]),
      .right       (volt[i+1]),
      .volt        (volt[i]),
      .sat         (cell_sat[i])
    );
  end

  // far end is pinned at rest; only reset or restart reloads it
  always_ff @(posedge clk) begin
    if (rst) begin
      far_cell <= ces_pkg::REST_RESET;
    end else if (cell_ctl.load) begin
      far_cell <= rest_potential;
    end
  end
  assign volt[GRID_POINTS] = far_cell;

  // sticky saturation flag
  always_ff @(posedge clk) begin
    if (rst) begin
      overflow_seen <= 1'b0;
    end else if (cell_ctl.load) begin
      overflow_seen <= 1'b0;
    end else if (front_ctl.drive && drive_sat) begin
      overflow_seen <= 1'b1;
    end else if (cell_ctl.acc && (|cell_sat)) begin
      overflow_seen <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.far_voltage <= overflow_seen ? ces_pkg::MINUS_ONE : volt[GRID_POINTS-1];
      out_data.overflow    <= overflow_seen;
    end
  end

  // checks
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ces_pkg::ST_DRIVE)
    else $error("accepted word did not start the drive step");

  a_flag_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.overflow |-> out_data.far_voltage == ces_pkg::MINUS_ONE)
    else $error("overflow result does not read -1.0");

  a_far_pinned: assert property (@(posedge clk) disable iff (rst)
    !cell_ctl.load |=> $stable(far_cell))
    else $error("far cell changed without restart");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ces_pkg::ST_PUT)
    else $error("result raised outside the output-load step");

endmodule

`default_nettype wire
